[rtl/core/kf2_pkg.sv]
package kf2_pkg;

    // input request: one measurement and a restart flag
    typedef struct packed {
        logic signed [31:0] measurement;
        logic               restart;
    } in_t;

    // output request: predicted state and covariance, with saturation and skip flags
    typedef struct packed {
        logic signed [31:0] est_position;
        logic signed [31:0] est_velocity;
        logic signed [31:0] cov_00;
        logic signed [31:0] cov_01;
        logic signed [31:0] cov_10;
        logic signed [31:0] cov_11;
        logic               saturated;
        logic               update_skipped;
    } out_t;

    // configuration register indexes
    localparam logic [2:0] CFG_STEP_DT      = 3'd0;
    localparam logic [2:0] CFG_MEAS_ROW_POS = 3'd1;
    localparam logic [2:0] CFG_MEAS_ROW_VEL = 3'd2;
    localparam logic [2:0] CFG_MEAS_NOISE   = 3'd3;
    localparam logic [2:0] CFG_CTRL_POS     = 3'd4;
    localparam logic [2:0] CFG_CTRL_VEL     = 3'd5;
    localparam logic [2:0] CFG_INIT_VAR     = 3'd6;

    // datapath operand / destination select
    typedef enum logic [4:0] {
        R_ZERO, R_ONE, R_X0, R_X1, R_P00, R_P01, R_P10, R_P11,
        R_T0, R_T1, R_S, R_Y, R_K0, R_K1, R_A00, R_A01, R_A10, R_A11,
        R_N00, R_N01, R_N10, R_N11, R_Z, R_HX,
        R_H0, R_H1, R_DT, R_R, R_CP, R_CV
    } reg_sel_t;

    // sequencer opcodes
    typedef enum logic [2:0] {
        OP_LD, OP_ADD, OP_SUB, OP_MAC, OP_MSB, OP_DIV, OP_BRS, OP_END
    } op_t;

    typedef struct packed {
        op_t      op;
        reg_sel_t a;
        reg_sel_t b;
        reg_sel_t dst;
        logic     wb;
    } instr_t;

    // datapath command kinds
    typedef enum logic [2:0] {
        DK_NOP, DK_LOAD, DK_ALU, DK_MUL, DK_ACC, DK_DIV
    } dp_kind_t;

    typedef struct packed {
        dp_kind_t kind;
        instr_t   ins;
    } dp_cmd_t;

    typedef struct packed {
        logic s_pos;
        logic div_done;
    } dp_stat_t;

    localparam int unsigned PC_W    = 6;
    localparam logic [5:0]  PRED_PC = 6'd45;

    function automatic instr_t mk(op_t op, reg_sel_t a, reg_sel_t b, reg_sel_t dst,
                                  logic wb);
        instr_t i;
        i.op  = op;
        i.a   = a;
        i.b   = b;
        i.dst = dst;
        i.wb  = wb;
        return i;
    endfunction

    // microprogram: update, then prediction from PRED_PC
    function automatic instr_t prog(logic [5:0] pc);
        instr_t i;
        case (pc)
            6'd0:  i = mk(OP_LD,  R_ZERO, R_ZERO, R_ZERO, 1'b0);
            6'd1:  i = mk(OP_MAC, R_P00, R_H0, R_ZERO, 1'b0);
            6'd2:  i = mk(OP_MAC, R_P01, R_H1, R_T0, 1'b1);
            6'd3:  i = mk(OP_LD,  R_ZERO, R_ZERO, R_ZERO, 1'b0);
            6'd4:  i = mk(OP_MAC, R_P10, R_H0, R_ZERO, 1'b0);
            6'd5:  i = mk(OP_MAC, R_P11, R_H1, R_T1, 1'b1);
            6'd6:  i = mk(OP_LD,  R_R, R_ZERO, R_ZERO, 1'b0);
            6'd7:  i = mk(OP_MAC, R_H0, R_T0, R_ZERO, 1'b0);
            6'd8:  i = mk(OP_MAC, R_H1, R_T1, R_S, 1'b1);
            6'd9:  i = mk(OP_LD,  R_ZERO, R_ZERO, R_ZERO, 1'b0);
            6'd10: i = mk(OP_MAC, R_H0, R_X0, R_ZERO, 1'b0);
            6'd11: i = mk(OP_MAC, R_H1, R_X1, R_HX, 1'b1);
            6'd12: i = mk(OP_LD,  R_Z, R_ZERO, R_ZERO, 1'b0);
            6'd13: i = mk(OP_SUB, R_HX, R_ZERO, R_Y, 1'b1);
            6'd14: i = mk(OP_BRS, R_ZERO, R_ZERO, R_ZERO, 1'b0);
            6'd15: i = mk(OP_DIV, R_T0, R_ZERO, R_K0, 1'b1);
            6'd16: i = mk(OP_DIV, R_T1, R_ZERO, R_K1, 1'b1);
            6'd17: i = mk(OP_LD,  R_ONE, R_ZERO, R_ZERO, 1'b0);
            6'd18: i = mk(OP_MSB, R_K0, R_H0, R_A00, 1'b1);
            6'd19: i = mk(OP_LD,  R_ZERO, R_ZERO, R_ZERO, 1'b0);
            6'd20: i = mk(OP_MSB, R_K0, R_H1, R_A01, 1'b1);
            6'd21: i = mk(OP_LD,  R_ZERO, R_ZERO, R_ZERO, 1'b0);
            6'd22: i = mk(OP_MSB, R_K1, R_H0, R_A10, 1'b1);
            6'd23: i = mk(OP_LD,  R_ONE, R_ZERO, R_ZERO, 1'b0);
            6'd24: i = mk(OP_MSB, R_K1, R_H1, R_A11, 1'b1);
            6'd25: i = mk(OP_LD,  R_X0, R_ZERO, R_ZERO, 1'b0);
            6'd26: i = mk(OP_MAC, R_K0, R_Y, R_X0, 1'b1);
            6'd27: i = mk(OP_LD,  R_X1, R_ZERO, R_ZERO, 1'b0);
            6'd28: i = mk(OP_MAC, R_K1, R_Y, R_X1, 1'b1);
            6'd29: i = mk(OP_LD,  R_ZERO, R_ZERO, R_ZERO, 1'b0);
            6'd30: i = mk(OP_MAC, R_A00, R_P00, R_ZERO, 1'b0);
            6'd31: i = mk(OP_MAC, R_A01, R_P10, R_N00, 1'b1);
            6'd32: i = mk(OP_LD,  R_ZERO, R_ZERO, R_ZERO, 1'b0);
            6'd33: i = mk(OP_MAC, R_A00, R_P01, R_ZERO, 1'b0);
            6'd34: i = mk(OP_MAC, R_A01, R_P11, R_N01, 1'b1);
            6'd35: i = mk(OP_LD,  R_ZERO, R_ZERO, R_ZERO, 1'b0);
            6'd36: i = mk(OP_MAC, R_A10, R_P00, R_ZERO, 1'b0);
            6'd37: i = mk(OP_MAC, R_A11, R_P10, R_N10, 1'b1);
            6'd38: i = mk(OP_LD,  R_ZERO, R_ZERO, R_ZERO, 1'b0);
            6'd39: i = mk(OP_MAC, R_A10, R_P01, R_ZERO, 1'b0);
            6'd40: i = mk(OP_MAC, R_A11, R_P11, R_N11, 1'b1);
            6'd41: i = mk(OP_LD,  R_N00, R_ZERO, R_P00, 1'b1);
            6'd42: i = mk(OP_LD,  R_N01, R_ZERO, R_P01, 1'b1);
            6'd43: i = mk(OP_LD,  R_N10, R_ZERO, R_P10, 1'b1);
            6'd44: i = mk(OP_LD,  R_N11, R_ZERO, R_P11, 1'b1);
            6'd45: i = mk(OP_LD,  R_X0, R_ZERO, R_ZERO, 1'b0);
            6'd46: i = mk(OP_MAC, R_DT, R_X1, R_ZERO, 1'b0);
            6'd47: i = mk(OP_ADD, R_CP, R_ZERO, R_X0, 1'b1);
            6'd48: i = mk(OP_LD,  R_X1, R_ZERO, R_ZERO, 1'b0);
            6'd49: i = mk(OP_ADD, R_CV, R_ZERO, R_X1, 1'b1);
            6'd50: i = mk(OP_LD,  R_P00, R_ZERO, R_ZERO, 1'b0);
            6'd51: i = mk(OP_MAC, R_DT, R_P10, R_P00, 1'b1);
            6'd52: i = mk(OP_LD,  R_P01, R_ZERO, R_ZERO, 1'b0);
            6'd53: i = mk(OP_MAC, R_DT, R_P11, R_P01, 1'b1);
            6'd54: i = mk(OP_LD,  R_P00, R_ZERO, R_ZERO, 1'b0);
            6'd55: i = mk(OP_MAC, R_P01, R_DT, R_P00, 1'b1);
            6'd56: i = mk(OP_LD,  R_P10, R_ZERO, R_ZERO, 1'b0);
            6'd57: i = mk(OP_MAC, R_P11, R_DT, R_P10, 1'b1);
            default: i = mk(OP_END, R_ZERO, R_ZERO, R_ZERO, 1'b0);
        endcase
        return i;
    endfunction

endpackage

[rtl/core/kf2_dp.sv]
module kf2_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  kf2_pkg::in_t      in_data,
    input  kf2_pkg::dp_cmd_t  cmd,
    output kf2_pkg::dp_stat_t stat,
    output kf2_pkg::out_t     res
);

    localparam int AW    = 66 - FRAC_BITS;
    localparam int DW    = 32 + FRAC_BITS;
    localparam int CW    = $clog2(DW + 1);
    localparam logic [31:0] ONE_FX   = 32'(1) << FRAC_BITS;
    localparam logic [31:0] INIT_RST = 32'(100) << FRAC_BITS;
    localparam logic signed [AW-1:0] MAX_A = AW'(64'sd2147483647);
    localparam logic signed [AW-1:0] MIN_A = AW'(-64'sd2147483648);

    // configuration
    logic signed [31:0] dt_reg, h0_reg, h1_reg, cp_reg, cv_reg;
    logic [30:0] r_reg, iv_reg;

    // working registers
    logic signed [31:0] x0_reg, x1_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] t0_reg, t1_reg, s_reg, y_reg, k0_reg, k1_reg;
    logic signed [31:0] a00_reg, a01_reg, a10_reg, a11_reg;
    logic signed [31:0] n00_reg, n01_reg, n10_reg, n11_reg, z_reg, hx_reg;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [63:0] prod_reg;
    logic sat_reg, sat_next;

    // divider
    logic [DW-1:0] q_reg, q_next;
    logic [31:0]   rem_reg, rem_next;
    logic [30:0]   den_reg;
    logic [CW-1:0] cnt_reg;
    logic          dneg_reg;
    kf2_pkg::reg_sel_t ddst_reg;
    logic [32:0]   rem_sh;
    logic          ge;
    logic          div_fin;
    logic [31:0]   div_val;
    logic          div_sat;

    logic signed [31:0] a_val, b_val;
    logic signed [63:0] prod_sh;
    logic signed [AW-1:0] fm;
    logic signed [31:0] wb_val;
    logic               wb_sat;
    logic               wr_en;
    kf2_pkg::reg_sel_t  wr_dst;
    logic signed [31:0] wr_val;
    logic [31:0]        amag;

    function automatic logic signed [31:0] rd(
        kf2_pkg::reg_sel_t sel,
        logic signed [31:0] x0, logic signed [31:0] x1,
        logic signed [31:0] p00, logic signed [31:0] p01,
        logic signed [31:0] p10, logic signed [31:0] p11,
        logic signed [31:0] t0, logic signed [31:0] t1,
        logic signed [31:0] s, logic signed [31:0] y,
        logic signed [31:0] k0, logic signed [31:0] k1,
        logic signed [31:0] a00, logic signed [31:0] a01,
        logic signed [31:0] a10, logic signed [31:0] a11,
        logic signed [31:0] n00, logic signed [31:0] n01,
        logic signed [31:0] n10, logic signed [31:0] n11,
        logic signed [31:0] z, logic signed [31:0] hx,
        logic signed [31:0] h0, logic signed [31:0] h1,
        logic signed [31:0] dt, logic signed [31:0] r,
        logic signed [31:0] cp, logic signed [31:0] cv,
        logic signed [31:0] one);
        logic signed [31:0] v;
        case (sel)
            kf2_pkg::R_ONE: v = one;
            kf2_pkg::R_X0:  v = x0;
            kf2_pkg::R_X1:  v = x1;
            kf2_pkg::R_P00: v = p00;
            kf2_pkg::R_P01: v = p01;
            kf2_pkg::R_P10: v = p10;
            kf2_pkg::R_P11: v = p11;
            kf2_pkg::R_T0:  v = t0;
            kf2_pkg::R_T1:  v = t1;
            kf2_pkg::R_S:   v = s;
            kf2_pkg::R_Y:   v = y;
            kf2_pkg::R_K0:  v = k0;
            kf2_pkg::R_K1:  v = k1;
            kf2_pkg::R_A00: v = a00;
            kf2_pkg::R_A01: v = a01;
            kf2_pkg::R_A10: v = a10;
            kf2_pkg::R_A11: v = a11;
            kf2_pkg::R_N00: v = n00;
            kf2_pkg::R_N01: v = n01;
            kf2_pkg::R_N10: v = n10;
            kf2_pkg::R_N11: v = n11;
            kf2_pkg::R_Z:   v = z;
            kf2_pkg::R_HX:  v = hx;
            kf2_pkg::R_H0:  v = h0;
            kf2_pkg::R_H1:  v = h1;
            kf2_pkg::R_DT:  v = dt;
            kf2_pkg::R_R:   v = r;
            kf2_pkg::R_CP:  v = cp;
            kf2_pkg::R_CV:  v = cv;
            default:        v = '0;
        endcase
        return v;
    endfunction

    // operand select
    always_comb
    begin
        a_val = rd(cmd.ins.a, x0_reg, x1_reg, p00_reg, p01_reg, p10_reg, p11_reg,
                   t0_reg, t1_reg, s_reg, y_reg, k0_reg, k1_reg,
                   a00_reg, a01_reg, a10_reg, a11_reg, n00_reg, n01_reg, n10_reg,
                   n11_reg, z_reg, hx_reg, h0_reg, h1_reg, dt_reg,
                   $signed({1'b0, r_reg}), cp_reg, cv_reg, $signed(ONE_FX));
        b_val = rd(cmd.ins.b, x0_reg, x1_reg, p00_reg, p01_reg, p10_reg, p11_reg,
                   t0_reg, t1_reg, s_reg, y_reg, k0_reg, k1_reg,
                   a00_reg, a01_reg, a10_reg, a11_reg, n00_reg, n01_reg, n10_reg,
                   n11_reg, z_reg, hx_reg, h0_reg, h1_reg, dt_reg,
                   $signed({1'b0, r_reg}), cp_reg, cv_reg, $signed(ONE_FX));
    end

    // accumulator: floor-shifted product, add/sub, clip on writeback
    always_comb
    begin
        prod_sh  = prod_reg >>> FRAC_BITS;
        fm       = prod_sh[AW-1:0];
        acc_next = acc_reg;
        case (cmd.kind)
            kf2_pkg::DK_ALU:
            begin
                case (cmd.ins.op)
                    kf2_pkg::OP_ADD: acc_next = acc_reg + AW'(a_val);
                    kf2_pkg::OP_SUB: acc_next = acc_reg - AW'(a_val);
                    default:         acc_next = AW'(a_val);
                endcase
            end
            kf2_pkg::DK_ACC:
            begin
                if (cmd.ins.op == kf2_pkg::OP_MSB)
                    acc_next = acc_reg - fm;
                else
                    acc_next = acc_reg + fm;
            end
            default: acc_next = acc_reg;
        endcase
        wb_sat = 1'b0;
        if (acc_next > MAX_A)
        begin
            wb_val = 32'sh7fffffff;
            wb_sat = 1'b1;
        end
        else if (acc_next < MIN_A)
        begin
            wb_val = 32'sh80000000;
            wb_sat = 1'b1;
        end
        else
        begin
            wb_val = acc_next[31:0];
        end
    end

    // restoring divider step, one quotient bit per cycle
    always_comb
    begin
        rem_sh   = {rem_reg, q_reg[DW-1]};
        ge       = rem_sh >= {2'b00, den_reg};
        rem_next = ge ? 32'(rem_sh - {2'b00, den_reg}) : rem_sh[31:0];
        q_next   = {q_reg[DW-2:0], ge};
        div_fin  = (cnt_reg == CW'(1));
        div_sat  = 1'b0;
        if (dneg_reg)
        begin
            if ((|q_next[DW-1:32]) || (q_next[31] && (|q_next[30:0])))
            begin
                div_val = 32'h80000000;
                div_sat = 1'b1;
            end
            else
            begin
                div_val = 32'(-q_next[31:0]);
            end
        end
        else if (|q_next[DW-1:31])
        begin
            div_val = 32'h7fffffff;
            div_sat = 1'b1;
        end
        else
        begin
            div_val = q_next[31:0];
        end
        amag = a_val[31] ? 32'(-a_val) : a_val;
    end

    // register file write port
    always_comb
    begin
        wr_en    = 1'b0;
        wr_dst   = cmd.ins.dst;
        wr_val   = wb_val;
        sat_next = sat_reg;
        if (div_fin)
        begin
            wr_en  = 1'b1;
            wr_dst = ddst_reg;
            wr_val = div_val;
            sat_next = sat_reg | div_sat;
        end
        else if ((cmd.kind == kf2_pkg::DK_ALU || cmd.kind == kf2_pkg::DK_ACC) &&
                 cmd.ins.wb)
        begin
            wr_en    = 1'b1;
            sat_next = sat_reg | wb_sat;
        end
        if (cmd.kind == kf2_pkg::DK_LOAD)
            sat_next = 1'b0;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg <= $signed(ONE_FX);
            h0_reg <= $signed(ONE_FX);
            h1_reg <= '0;
            r_reg  <= ONE_FX[30:0];
            cp_reg <= '0;
            cv_reg <= '0;
            iv_reg <= INIT_RST[30:0];
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kf2_pkg::CFG_STEP_DT:      dt_reg <= cfg_data;
                kf2_pkg::CFG_MEAS_ROW_POS: h0_reg <= cfg_data;
                kf2_pkg::CFG_MEAS_ROW_VEL: h1_reg <= cfg_data;
                kf2_pkg::CFG_MEAS_NOISE:   r_reg  <= cfg_data[30:0];
                kf2_pkg::CFG_CTRL_POS:     cp_reg <= cfg_data;
                kf2_pkg::CFG_CTRL_VEL:     cv_reg <= cfg_data;
                kf2_pkg::CFG_INIT_VAR:     iv_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // filter state, control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x0_reg  <= '0;
            x1_reg  <= '0;
            p00_reg <= $signed(INIT_RST);
            p01_reg <= '0;
            p10_reg <= '0;
            p11_reg <= $signed(INIT_RST);
            sat_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            sat_reg <= sat_next;
            if (cmd.kind == kf2_pkg::DK_LOAD && in_data.restart)
            begin
                x0_reg  <= '0;
                x1_reg  <= '0;
                p00_reg <= $signed({1'b0, iv_reg});
                p01_reg <= '0;
                p10_reg <= '0;
                p11_reg <= $signed({1'b0, iv_reg});
            end
            if (cmd.kind == kf2_pkg::DK_DIV)
                cnt_reg <= CW'(DW);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - CW'(1);
            if (wr_en)
            begin
                case (wr_dst)
                    kf2_pkg::R_X0:  x0_reg  <= wr_val;
                    kf2_pkg::R_X1:  x1_reg  <= wr_val;
                    kf2_pkg::R_P00: p00_reg <= wr_val;
                    kf2_pkg::R_P01: p01_reg <= wr_val;
                    kf2_pkg::R_P10: p10_reg <= wr_val;
                    kf2_pkg::R_P11: p11_reg <= wr_val;
                    default: ;
                endcase
            end
        end
    end

    // scratch registers, accumulator, multiplier, divider data
    always_ff @(posedge clk)
    begin
        if (cmd.kind == kf2_pkg::DK_LOAD)
            z_reg <= in_data.measurement;
        if (cmd.kind == kf2_pkg::DK_ALU || cmd.kind == kf2_pkg::DK_ACC)
            acc_reg <= acc_next;
        if (cmd.kind == kf2_pkg::DK_MUL)
            prod_reg <= a_val * b_val;
        if (cmd.kind == kf2_pkg::DK_DIV)
        begin
            q_reg    <= DW'(amag) << FRAC_BITS;
            rem_reg  <= '0;
            den_reg  <= s_reg[30:0];
            dneg_reg <= a_val[31];
            ddst_reg <= cmd.ins.dst;
        end
        else
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
        if (wr_en)
        begin
            case (wr_dst)
                kf2_pkg::R_T0:  t0_reg  <= wr_val;
                kf2_pkg::R_T1:  t1_reg  <= wr_val;
                kf2_pkg::R_S:   s_reg   <= wr_val;
                kf2_pkg::R_Y:   y_reg   <= wr_val;
                kf2_pkg::R_K0:  k0_reg  <= wr_val;
                kf2_pkg::R_K1:  k1_reg  <= wr_val;
                kf2_pkg::R_A00: a00_reg <= wr_val;
                kf2_pkg::R_A01: a01_reg <= wr_val;
                kf2_pkg::R_A10: a10_reg <= wr_val;
                kf2_pkg::R_A11: a11_reg <= wr_val;
                kf2_pkg::R_N00: n00_reg <= wr_val;
                kf2_pkg::R_N01: n01_reg <= wr_val;
                kf2_pkg::R_N10: n10_reg <= wr_val;
                kf2_pkg::R_N11: n11_reg <= wr_val;
                kf2_pkg::R_HX:  hx_reg  <= wr_val;
                default: ;
            endcase
        end
    end

    // status and result
    assign stat.s_pos    = !s_reg[31] && (s_reg != '0);
    assign stat.div_done = div_fin;

    assign res.est_position   = x0_reg;
    assign res.est_velocity   = x1_reg;
    assign res.cov_00         = p00_reg;
    assign res.cov_01         = p01_reg;
    assign res.cov_10         = p10_reg;
    assign res.cov_11         = p11_reg;
    assign res.saturated      = sat_reg;
    assign res.update_skipped = 1'b0;

endmodule

[rtl/core/kf2_ctrl.sv]
module kf2_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  kf2_pkg::dp_stat_t stat,
    output kf2_pkg::dp_cmd_t  cmd,
    output logic              out_load,
    output logic              skipped
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_EXEC, ST_ACC, ST_DIVW, ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [kf2_pkg::PC_W-1:0] pc_reg, pc_next;
    logic skip_reg, skip_next;
    logic oval_reg, oval_next;
    kf2_pkg::instr_t ins;

    assign ins      = kf2_pkg::prog(pc_reg);
    assign in_stall = (state_reg != ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (!oval_reg || !out_stall);

    // sequencing and command decode
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        skip_next  = skip_reg;
        oval_next  = oval_reg && out_stall;
        cmd.kind   = kf2_pkg::DK_NOP;
        cmd.ins    = ins;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.kind   = kf2_pkg::DK_LOAD;
                    pc_next    = '0;
                    skip_next  = 1'b0;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (ins.op)
                    kf2_pkg::OP_MAC, kf2_pkg::OP_MSB:
                    begin
                        cmd.kind   = kf2_pkg::DK_MUL;
                        state_next = ST_ACC;
                    end
                    kf2_pkg::OP_DIV:
                    begin
                        cmd.kind   = kf2_pkg::DK_DIV;
                        state_next = ST_DIVW;
                    end
                    kf2_pkg::OP_BRS:
                    begin
                        if (stat.s_pos)
                            pc_next = pc_reg + 1'b1;
                        else
                        begin
                            skip_next = 1'b1;
                            pc_next   = kf2_pkg::PRED_PC;
                        end
                    end
                    kf2_pkg::OP_END:
                    begin
                        state_next = ST_OUT;
                    end
                    default:
                    begin
                        cmd.kind = kf2_pkg::DK_ALU;
                        pc_next  = pc_reg + 1'b1;
                    end
                endcase
            end
            ST_ACC:
            begin
                cmd.kind   = kf2_pkg::DK_ACC;
                pc_next    = pc_reg + 1'b1;
                state_next = ST_EXEC;
            end
            ST_DIVW:
            begin
                if (stat.div_done)
                begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    oval_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state and registered flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
            skip_reg  <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            skip_reg  <= skip_next;
            oval_reg  <= oval_next;
        end
    end

    assign out_valid = oval_reg;
    assign skipped   = skip_reg;

endmodule

[rtl/core/kalman_filter_2state_1meas.sv]
// Two-state constant-velocity Kalman filter, one position measurement per request.
// Input channel: in_valid / in_stall / in_data (measurement, restart). A request
// is taken when in_valid is high and in_stall low; in_stall stays high while a
// request is being worked on, so one request is in flight at a time.
// Output channel: out_valid / out_stall / out_data; one result per request, held
// in an output register until taken, so a result may wait while the next request
// is already being worked on. A stalled result holds its value.
// Datapath: a microprogram drives one 32x32 multiplier and a restoring divider
// (one quotient bit per cycle). When the innovation variance is not positive,
// the update is skipped and only the prediction runs. in_stall drops in the
// cycle out_valid rises. If the previous result is still stalled, the next
// request finishes and then holds in_stall high until that result is taken.
// Configuration: cfg_we / cfg_index / cfg_data write registers 0..6; the user
// must write them only while idle, as the block itself does not enforce it;
// other indexes are ignored.
// Reset: registers take their default values, the estimate clears, the
// covariance loads 100.0 on its diagonal, and no result is pending.
module kalman_filter_2state_1meas #(
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  kf2_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output kf2_pkg::out_t out_data,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data
);

    kf2_pkg::dp_cmd_t  cmd;
    kf2_pkg::dp_stat_t stat;
    kf2_pkg::out_t     res;
    kf2_pkg::out_t     res_full;
    kf2_pkg::out_t     out_reg;
    logic              out_load;
    logic              skipped;

    kf2_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd),
        .out_load  (out_load),
        .skipped   (skipped)
    );

    kf2_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .res       (res)
    );

    // merge the skip flag from the controller
    always_comb
    begin
        res_full                = res;
        res_full.update_skipped = skipped;
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= res_full;
    end

    assign out_data = out_reg;

endmodule

[rtl/core/kf2_chk.sv]
module kf2_chk (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_stall,
    input logic          out_valid,
    input logic          out_stall,
    input kf2_pkg::out_t out_data
);

    // a stalled result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("stalled result changed");

    // one request in flight
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken while busy");

    // a new result only comes out of a busy period
    a_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a request");

endmodule

bind kalman_filter_2state_1meas kf2_chk u_kf2_chk (.*);

[tb/sv/kalman_filter_2state_1meas_tb.sv]
`timescale 1ns / 1ps

module kalman_filter_2state_1meas_tb;

    localparam int          FRAC      = 16;
    localparam longint      ONE_Q     = longint'(1) << FRAC;
    localparam longint      Q_MAX     = 64'sd2147483647;
    localparam longint      Q_MIN     = -64'sd2147483648;
    localparam logic [2:0]  CFG_SPARE = 3'd7;   // no register behind this index

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_stall;
    kf2_pkg::in_t    in_data;
    logic            out_valid;
    logic            out_stall = 1'b0;
    kf2_pkg::out_t   out_data;
    logic            cfg_we;
    logic [2:0]      cfg_index;
    logic [31:0]     cfg_data;

    kalman_filter_2state_1meas DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // filter registers and state as the block should hold them
    longint dt_q, h_pos, h_vel, r_noise, c_pos, c_vel, p_init;
    longint est[2];
    longint cov[4];
    bit     clipped;

    kf2_pkg::out_t result_q[$];
    int     errors;
    bit     stall_quiet;
    int     stall_run = 0;
    bit     stall_level = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #40ms;
        $display("FAIL");
        $finish;
    end

    function automatic longint sat32(longint v);
        if (v > Q_MAX)
        begin
            clipped = 1'b1;
            return Q_MAX;
        end
        if (v < Q_MIN)
        begin
            clipped = 1'b1;
            return Q_MIN;
        end
        return v;
    endfunction

    // product rounded toward minus infinity
    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> FRAC;
    endfunction

    function automatic void load_start();
        est[0] = 0;
        est[1] = 0;
        cov[0] = p_init;
        cov[1] = 0;
        cov[2] = 0;
        cov[3] = p_init;
    endfunction

    function automatic void model_reset();
        dt_q    = ONE_Q;
        h_pos   = ONE_Q;
        h_vel   = 0;
        r_noise = ONE_Q;
        c_pos   = 0;
        c_vel   = 0;
        p_init  = 100 * ONE_Q;
        load_start();
    endfunction

    // one filter cycle: update then prediction
    function automatic kf2_pkg::out_t filter_step(kf2_pkg::in_t req);
        kf2_pkg::out_t r;
        longint x0, x1, p00, p01, p10, p11, t0, t1, s, hx, y;
        longint k0, k1, a00, a01, a10, a11, n00, n01, n10, n11, m00, m01;
        bit     skip;
        clipped = 1'b0;
        skip = 1'b0;
        if (req.restart)
            load_start();
        x0 = est[0];
        x1 = est[1];
        p00 = cov[0];
        p01 = cov[1];
        p10 = cov[2];
        p11 = cov[3];
        t0 = sat32(qmul(p00, h_pos) + qmul(p01, h_vel));
        t1 = sat32(qmul(p10, h_pos) + qmul(p11, h_vel));
        s  = sat32(qmul(h_pos, t0) + qmul(h_vel, t1) + r_noise);
        hx = sat32(qmul(h_pos, x0) + qmul(h_vel, x1));
        y  = sat32(longint'(req.measurement) - hx);
        if (s <= 0)
            skip = 1'b1;
        else
        begin
            k0  = sat32((t0 * ONE_Q) / s);
            k1  = sat32((t1 * ONE_Q) / s);
            a00 = sat32(ONE_Q - qmul(k0, h_pos));
            a01 = sat32(-qmul(k0, h_vel));
            a10 = sat32(-qmul(k1, h_pos));
            a11 = sat32(ONE_Q - qmul(k1, h_vel));
            x0  = sat32(x0 + qmul(k0, y));
            x1  = sat32(x1 + qmul(k1, y));
            n00 = sat32(qmul(a00, p00) + qmul(a01, p10));
            n01 = sat32(qmul(a00, p01) + qmul(a01, p11));
            n10 = sat32(qmul(a10, p00) + qmul(a11, p10));
            n11 = sat32(qmul(a10, p01) + qmul(a11, p11));
            p00 = n00;
            p01 = n01;
            p10 = n10;
            p11 = n11;
        end
        x0  = sat32(x0 + qmul(dt_q, x1) + c_pos);
        x1  = sat32(x1 + c_vel);
        m00 = sat32(p00 + qmul(dt_q, p10));
        m01 = sat32(p01 + qmul(dt_q, p11));
        p00 = sat32(m00 + qmul(m01, dt_q));
        p10 = sat32(p10 + qmul(p11, dt_q));
        p01 = m01;
        est[0] = x0;
        est[1] = x1;
        cov[0] = p00;
        cov[1] = p01;
        cov[2] = p10;
        cov[3] = p11;
        r.est_position   = x0[31:0];
        r.est_velocity   = x1[31:0];
        r.cov_00         = p00[31:0];
        r.cov_01         = p01[31:0];
        r.cov_10         = p10[31:0];
        r.cov_11         = p11[31:0];
        r.saturated      = clipped;
        r.update_skipped = skip;
        return r;
    endfunction

    // register write, mirrored into the model
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            kf2_pkg::CFG_STEP_DT:      dt_q    = longint'($signed(val));
            kf2_pkg::CFG_MEAS_ROW_POS: h_pos   = longint'($signed(val));
            kf2_pkg::CFG_MEAS_ROW_VEL: h_vel   = longint'($signed(val));
            kf2_pkg::CFG_MEAS_NOISE:   r_noise = longint'({33'd0, val[30:0]});
            kf2_pkg::CFG_CTRL_POS:     c_pos   = longint'($signed(val));
            kf2_pkg::CFG_CTRL_VEL:     c_vel   = longint'($signed(val));
            kf2_pkg::CFG_INIT_VAR:     p_init  = longint'({33'd0, val[30:0]});
            default:                   ;
        endcase
    endtask

    task automatic write_all(logic [31:0] dt, logic [31:0] hp, logic [31:0] hv,
                             logic [31:0] rn, logic [31:0] cp, logic [31:0] cv,
                             logic [31:0] pi);
        write_reg(kf2_pkg::CFG_STEP_DT, dt);
        write_reg(kf2_pkg::CFG_MEAS_ROW_POS, hp);
        write_reg(kf2_pkg::CFG_MEAS_ROW_VEL, hv);
        write_reg(kf2_pkg::CFG_MEAS_NOISE, rn);
        write_reg(kf2_pkg::CFG_CTRL_POS, cp);
        write_reg(kf2_pkg::CFG_CTRL_VEL, cv);
        write_reg(kf2_pkg::CFG_INIT_VAR, pi);
    endtask

    // let every result drain, then give the block time to settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // present one request, hold it until taken, then idle for the gap
    task automatic send_request(logic [31:0] meas, logic rst_est, int gap);
        kf2_pkg::in_t req;
        req.measurement = meas;
        req.restart     = rst_est;
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (in_stall);
        result_q.push_back(filter_step(req));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] rand_meas();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return 32'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
    endfunction

    // receiver back-pressure: mostly short stalls, some long, quiet stretches
    always @(posedge clk)
    begin
        if (stall_quiet)
        begin
            stall_run   <= 0;
            stall_level <= 1'b0;
        end
        else if (stall_run > 0)
            stall_run <= stall_run - 1;
        else if ($urandom_range(0, 99) < 55)
        begin
            stall_level <= 1'b0;
            stall_run   <= $urandom_range(0, 6);
        end
        else
        begin
            stall_level <= 1'b1;
            stall_run   <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                        : $urandom_range(0, 3);
        end
    end

    always @(posedge clk)
        out_stall <= stall_level;

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, got_v);
            errors++;
        end
    endtask

    // compare each taken result with the oldest prediction
    always @(posedge clk)
    begin
        kf2_pkg::out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (result_q.size() == 0)
            begin
                $error("result with no request pending");
                errors++;
            end
            else
            begin
                want = result_q.pop_front();
                check_field("est_position", want.est_position, out_data.est_position);
                check_field("est_velocity", want.est_velocity, out_data.est_velocity);
                check_field("cov_00", want.cov_00, out_data.cov_00);
                check_field("cov_01", want.cov_01, out_data.cov_01);
                check_field("cov_10", want.cov_10, out_data.cov_10);
                check_field("cov_11", want.cov_11, out_data.cov_11);
                check_field("saturated", 32'(want.saturated), 32'(out_data.saturated));
                check_field("update_skipped", 32'(want.update_skipped),
                            32'(out_data.update_skipped));
            end
        end
    end

    // default registers, measurement extremes and restart
    task automatic test_defaults();
        stall_quiet = 1'b1;
        send_request(32'h0000_0000, 1'b0, 0);
        send_request(32'h7FFF_FFFF, 1'b0, 0);
        send_request(32'h8000_0000, 1'b0, 2);
        send_request(32'h0001_0000, 1'b1, 0);
        send_request(32'hFFFF_0000, 1'b0, 0);
        stall_quiet = 1'b0;
        send_request(32'h0003_8000, 1'b0, 5);
        send_request(32'h0005_0000, 1'b1, 0);
        send_request(32'hFFFF_FFFF, 1'b0, 0);
        drain_results();
    endtask

    // zero and negative innovation variance skip the update
    task automatic test_skipped_update();
        write_all(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0064_0000);
        send_request(32'h0002_0000, 1'b1, 0);
        send_request(32'hFFFE_0000, 1'b0, 0);
        drain_results();
        // huge measurement row on a large variance saturates S and the products
        write_all(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0,
                  32'h7FFF_FFFF);
        write_reg(CFG_SPARE, 32'hDEAD_BEEF);
        send_request(32'h7FFF_FFFF, 1'b1, 0);
        send_request(32'h8000_0000, 1'b0, 0);
        send_request(32'h0, 1'b0, 0);
        drain_results();
    endtask

    // register extremes with clipping everywhere
    task automatic test_saturation();
        write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(32'h7FFF_FFFF, 1'b1, 0);
        send_request(32'h8000_0000, 1'b0, 0);
        send_request(32'h1234_5678, 1'b0, 0);
        drain_results();
        write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'h8000_0000, 1'b1, 0);
        send_request(32'h7FFF_FFFF, 1'b0, 0);
        drain_results();
    endtask

    // random phases: mostly plausible tracking setups, some raw registers
    task automatic test_random_tracking();
        int n;
        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph % 4 == 3)
                write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom);
            else
                write_all($urandom_range(0, 32'h0002_0000),
                          32'h0001_0000 + $urandom_range(0, 32'h8000) - 32'h4000,
                          $urandom_range(0, 32'h4000) - 32'h2000,
                          $urandom_range(0, 32'h0040_0000),
                          $urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
                          $urandom_range(0, 32'h2000) - 32'h1000,
                          $urandom_range(0, 32'h1000_0000));
            stall_quiet = (ph % 5 == 2);
            n = 115;
            for (int i = 0; i < n; i++)
                send_request(rand_meas(), ($urandom_range(0, 19) == 0) || (i == 0),
                             stall_quiet ? 0 : pick_gap());
            drain_results();
        end
        stall_quiet = 1'b0;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        errors      = 0;
        stall_quiet = 1'b0;
        model_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_skipped_update();
        test_saturation();
        test_random_tracking();

        if (result_q.size() != 0)
        begin
            $error("%0d results never arrived", result_q.size());
            errors++;
        end
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
rtl/core/kf2_pkg.sv
rtl/core/kf2_dp.sv
rtl/core/kf2_ctrl.sv
rtl/core/kalman_filter_2state_1meas.sv
rtl/core/kf2_chk.sv
tb/sv/kalman_filter_2state_1meas_tb.sv
